// File: src/act_pkg.sv
// shared types, constants and helper functions of the command tokenizer
package act_pkg;

    localparam int KW_COUNT = 7;

    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_SEMI  = 8'd59;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_POINT = 8'd46;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_LOW_A = 8'd97;
    localparam logic [7:0] CHAR_LOW_Z = 8'd122;
    localparam logic [7:0] CASE_DIFF  = 8'd32;
    localparam logic [7:0] CHAR_NUL   = 8'd0;

    localparam int LEN_W  = 6;
    localparam int INT_W  = 20;
    localparam int FRAC_W = 14;
    localparam int CNT_W  = 3;
    localparam int QFRAC_W = 10;

    localparam logic [INT_W-1:0] INT_MAX = 20'd1048575;
    localparam logic [6:0]       KW_ALL  = 7'h7f;

    // floor(x * 1024 / 10000) == (x * FRAC_RECIP) >> FRAC_SHIFT for x < 10000
    localparam logic [19:0] FRAC_RECIP = 20'd858994;
    localparam int          FRAC_SHIFT = 23;

    // keyword text, left aligned and padded with spaces
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        "ON    ", "OFF   ", "STOP  ", "LOOP  ", "WALK  ", "SINE  ", "COSINE"
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        6'd2, 6'd3, 6'd4, 6'd4, 6'd4, 6'd4, 6'd6
    };

    typedef enum logic [3:0] {
        KIND_ON       = 4'd0,
        KIND_OFF      = 4'd1,
        KIND_STOP     = 4'd2,
        KIND_LOOP     = 4'd3,
        KIND_WALK     = 4'd4,
        KIND_SINE     = 4'd5,
        KIND_COSINE   = 4'd6,
        KIND_NUMBER   = 4'd7,
        KIND_INVALID  = 4'd8,
        KIND_OVERFLOW = 4'd9
    } t_kind;

    typedef enum logic [3:0] {
        PH_SPACES = 4'b0001,
        PH_INT    = 4'b0010,
        PH_FRAC   = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [6:0]        flags;
        logic              saw_digit;
        logic              only_num;
        logic [INT_W-1:0]  int_acc;
        logic [FRAC_W-1:0] frac_acc;
        logic              term;
        logic              ovf;
    } t_scan_state;

    function automatic logic [7:0] kw_byte(input logic [47:0] text, input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = text[47:40];
            3'd1:    c = text[39:32];
            3'd2:    c = text[31:24];
            3'd3:    c = text[23:16];
            3'd4:    c = text[15:8];
            3'd5:    c = text[7:0];
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    // weight of the next fraction digit, so the sum is always scaled to four digits
    function automatic logic [9:0] digit_weight(input logic [CNT_W-1:0] cnt);
        logic [9:0] w;
        case (cnt)
            3'd0:    w = 10'd1000;
            3'd1:    w = 10'd100;
            3'd2:    w = 10'd10;
            3'd3:    w = 10'd1;
            default: w = 10'd0;
        endcase
        return w;
    endfunction

endpackage

// File: src/act_in_if.sv
// byte input channel
interface act_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// File: src/act_out_if.sv
// token result channel
interface act_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [29:0] number_value;

    modport source (output valid, output token_kind, output number_value, input ready);
    modport sink   (input valid, input token_kind, input number_value, output ready);
endinterface

// File: src/act_scan.sv
// per-byte token state: keyword match, number accumulation, length and overflow
module act_scan #(
    parameter int BUFFER_LENGTH   = 32,
    parameter int FRACTION_DIGITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_byte,
    output act_pkg::t_scan_state o_state
);

    localparam logic [act_pkg::LEN_W-1:0] LEN_LIMIT  = act_pkg::LEN_W'(BUFFER_LENGTH - 1);
    localparam logic [act_pkg::CNT_W-1:0] FRAC_LIMIT = act_pkg::CNT_W'(FRACTION_DIGITS);

    logic [act_pkg::LEN_W-1:0]  r_len,   n_len;
    logic [6:0]                 r_flags, n_flags;
    logic                       r_saw,   n_saw;
    logic                       r_only,  n_only;
    act_pkg::t_phase            r_phase, n_phase;
    logic [act_pkg::INT_W-1:0]  r_int,   n_int;
    logic [act_pkg::FRAC_W-1:0] r_frac,  n_frac;
    logic [act_pkg::CNT_W-1:0]  r_cnt,   n_cnt;
    logic                       r_term,  n_term;
    logic                       r_ovf,   n_ovf;

    logic [7:0]  b;
    logic        is_term;
    logic        is_digit;
    logic [3:0]  digit;
    logic [23:0] int_x10;
    logic [act_pkg::FRAC_W-1:0] frac_add;

    always_comb begin
        b = i_byte;
        if (i_byte >= act_pkg::CHAR_LOW_A && i_byte <= act_pkg::CHAR_LOW_Z) begin
            b = i_byte - act_pkg::CASE_DIFF;
        end
        is_term  = (i_byte == act_pkg::CHAR_NL) || (i_byte == act_pkg::CHAR_SEMI);
        is_digit = (b >= act_pkg::CHAR_ZERO) && (b <= act_pkg::CHAR_NINE);
        digit    = b[3:0];
        int_x10  = ({4'd0, r_int} << 3) + ({4'd0, r_int} << 1) + {20'd0, digit};
        frac_add = act_pkg::FRAC_W'(digit) * act_pkg::FRAC_W'(act_pkg::digit_weight(r_cnt));

        n_len   = r_len;
        n_flags = r_flags;
        n_saw   = r_saw;
        n_only  = r_only;
        n_phase = r_phase;
        n_int   = r_int;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_term  = r_term;
        n_ovf   = r_ovf;

        if (i_en) begin
            if (is_term) begin
                n_len   = '0;
                n_flags = act_pkg::KW_ALL;
                n_saw   = 1'b0;
                n_only  = 1'b1;
                n_phase = act_pkg::PH_SPACES;
                n_int   = '0;
                n_frac  = '0;
                n_cnt   = '0;
                n_term  = 1'b0;
                n_ovf   = 1'b0;
            end else if (!r_ovf) begin
                if (r_len >= LEN_LIMIT) begin
                    n_ovf = 1'b1;
                end else begin
                    n_len = r_len + 1'b1;
                    if (!r_term) begin
                        if (b == act_pkg::CHAR_NUL) begin
                            // keep only keywords complete exactly here
                            for (int k = 0; k < act_pkg::KW_COUNT; k++) begin
                                if (r_len != act_pkg::KW_LEN[k]) begin
                                    n_flags[k] = 1'b0;
                                end
                            end
                            n_term = 1'b1;
                        end else begin
                            for (int k = 0; k < act_pkg::KW_COUNT; k++) begin
                                if (!(r_len < act_pkg::KW_LEN[k] &&
                                      act_pkg::kw_byte(act_pkg::KW_TEXT[k], r_len[2:0]) == b)) begin
                                    n_flags[k] = 1'b0;
                                end
                            end
                            if (is_digit) begin
                                n_saw = 1'b1;
                            end else if (b != act_pkg::CHAR_SPACE && b != act_pkg::CHAR_POINT) begin
                                n_only = 1'b0;
                            end
                            unique case (r_phase) inside
                                act_pkg::PH_SPACES, act_pkg::PH_INT: begin
                                    if (is_digit) begin
                                        n_int = (int_x10 > {4'd0, act_pkg::INT_MAX}) ?
                                                act_pkg::INT_MAX : int_x10[act_pkg::INT_W-1:0];
                                        n_phase = act_pkg::PH_INT;
                                    end else if (b == act_pkg::CHAR_POINT) begin
                                        n_phase = act_pkg::PH_FRAC;
                                    end else if (!(b == act_pkg::CHAR_SPACE &&
                                                   r_phase == act_pkg::PH_SPACES)) begin
                                        n_phase = act_pkg::PH_DONE;
                                    end
                                end
                                act_pkg::PH_FRAC: begin
                                    if (is_digit) begin
                                        if (r_cnt < FRAC_LIMIT) begin
                                            n_frac = r_frac + frac_add;
                                            n_cnt  = r_cnt + 1'b1;
                                        end
                                    end else begin
                                        n_phase = act_pkg::PH_DONE;
                                    end
                                end
                                act_pkg::PH_DONE: begin
                                end
                                default: begin
                                    n_phase = act_pkg::PH_DONE;
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_flags <= act_pkg::KW_ALL;
            r_saw   <= 1'b0;
            r_only  <= 1'b1;
            r_phase <= act_pkg::PH_SPACES;
            r_int   <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
            r_term  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_flags <= n_flags;
            r_saw   <= n_saw;
            r_only  <= n_only;
            r_phase <= n_phase;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_cnt   <= n_cnt;
            r_term  <= n_term;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        o_state.len       = r_len;
        o_state.flags     = r_flags;
        o_state.saw_digit = r_saw;
        o_state.only_num  = r_only;
        o_state.int_acc   = r_int;
        o_state.frac_acc  = r_frac;
        o_state.term      = r_term;
        o_state.ovf       = r_ovf;
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_LIMIT)
        else $error("token length beyond buffer");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_len == LEN_LIMIT)
        else $error("overflow with buffer not full");

    a_empty_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len == '0 |-> (r_flags == act_pkg::KW_ALL && !r_term && r_saw == 1'b0))
        else $error("empty token with stale match state");

endmodule

// File: src/act_classify.sv
// end-of-token decision: keyword, number with fixed-point fraction, invalid or overflow
module act_classify (
    input  act_pkg::t_scan_state i_state,
    output act_pkg::t_kind       o_kind,
    output logic [29:0]          o_value
);

    logic                         found;
    logic [33:0]                  prod;
    logic [act_pkg::QFRAC_W-1:0]  frac;

    always_comb begin
        found  = 1'b0;
        o_kind = act_pkg::KIND_INVALID;
        // scan downward so the lowest matching keyword wins
        for (int k = act_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (i_state.flags[k] && (i_state.term || i_state.len == act_pkg::KW_LEN[k])) begin
                found  = 1'b1;
                o_kind = act_pkg::t_kind'(4'(k));
            end
        end

        prod = 34'(i_state.frac_acc) * 34'(act_pkg::FRAC_RECIP);
        frac = act_pkg::QFRAC_W'(prod >> act_pkg::FRAC_SHIFT);

        o_value = '0;
        if (i_state.ovf) begin
            o_kind = act_pkg::KIND_OVERFLOW;
        end else if (!found && i_state.saw_digit && i_state.only_num) begin
            o_kind  = act_pkg::KIND_NUMBER;
            o_value = {i_state.int_acc, frac};
        end
    end

endmodule

// File: src/ascii_command_tokenizer_unit.sv
// Command tokenizer: one received byte per transaction in, one token result per
// non-empty token out. A byte is registered on input and then handled from that
// register against the running token state (keyword match flags, integer and scaled
// fraction accumulators), so one byte is taken every cycle with no stall while the
// result register has room. A newline or semicolon produces the result from that
// state in the same cycle (one 14x20 multiply turns the four-digit fraction into
// ten fraction bits) and the result sits in the output register until taken; a
// byte can still enter while a result waits. A terminator waits in the input register
// until the result register has room. Results: keyword codes 0 to 6, number 7 (20.10 fixed
// point, integer saturated), invalid 8, overflow 9 for tokens longer than
// BUFFER_LENGTH-1 bytes.
module ascii_command_tokenizer_unit #(
    parameter int BUFFER_LENGTH   = 32,
    parameter int FRACTION_DIGITS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    act_in_if.sink    i_in,
    act_out_if.source o_out
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid, n_out_valid;
    logic [3:0]  r_out_kind;
    logic [29:0] r_out_value;

    act_pkg::t_scan_state scan_state;
    act_pkg::t_kind       res_kind;
    logic [29:0]          res_value;

    logic in_is_term;
    logic out_free;
    logic go;
    logic emit;

    assign in_is_term = (r_in_byte == act_pkg::CHAR_NL) || (r_in_byte == act_pkg::CHAR_SEMI);
    assign out_free   = !r_out_valid || o_out.ready;
    // only a terminator needs room in the result register
    assign go         = r_in_valid && (out_free || !in_is_term);
    assign emit       = go && in_is_term && (scan_state.len != '0 || scan_state.ovf);
    assign i_in.ready = !r_in_valid || go;

    act_scan #(
        .BUFFER_LENGTH   (BUFFER_LENGTH),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (go),
        .i_byte  (r_in_byte),
        .o_state (scan_state)
    );

    act_classify u_classify (
        .i_state (scan_state),
        .o_kind  (res_kind),
        .o_value (res_value)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.byte_in;
        end
        if (emit) begin
            r_out_kind  <= res_kind;
            r_out_value <= res_value;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.token_kind   = r_out_kind;
    assign o_out.number_value = r_out_value;

    a_value_only_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != act_pkg::KIND_NUMBER) |-> r_out_value == '0)
        else $error("number value set on a non-number result");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_kind <= act_pkg::KIND_OVERFLOW)
        else $error("result kind out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=>
            (r_out_valid && $stable(r_out_kind) && $stable(r_out_value)))
        else $error("waiting result changed");

endmodule

// File: dv/ascii_command_tokenizer_unit_tb.sv
// testbench of the command tokenizer: directed tokens, then random byte streams against a predictor
module ascii_command_tokenizer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_LEN     = 32;
    localparam int FRAC_KEEP   = 4;
    localparam int STUCK_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        act_pkg::t_kind kind;
        logic [29:0]    value;
    } t_token_res;

    typedef enum {
        PREDICTED,
        TYPED_RESULT,
        TYPED_NONE
    } t_check_src;

    typedef struct {
        string          text;
        int             nul_pos;
        logic [7:0]     term;
        t_check_src     src;
        act_pkg::t_kind kind;
        logic [29:0]    value;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    act_in_if  byte_ch ();
    act_out_if token_ch ();

    ascii_command_tokenizer_unit #(
        .BUFFER_LENGTH   (BUF_LEN),
        .FRACTION_DIGITS (FRAC_KEEP)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (token_ch)
    );

    string kw_spell [act_pkg::KW_COUNT] = '{"ON", "OFF", "STOP", "LOOP", "WALK", "SINE",
                                            "COSINE"};

    t_directed_row directed_rows [26] = '{
        '{"on",     -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_ON,      30'd0},
        '{"OFF",    -1, act_pkg::CHAR_SEMI, TYPED_RESULT, act_pkg::KIND_OFF,     30'd0},
        '{"Stop",   -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_STOP,    30'd0},
        '{"lOOp",   -1, act_pkg::CHAR_SEMI, TYPED_RESULT, act_pkg::KIND_LOOP,    30'd0},
        '{"walk",   -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_WALK,    30'd0},
        '{"sine",   -1, act_pkg::CHAR_SEMI, TYPED_RESULT, act_pkg::KIND_SINE,    30'd0},
        '{"COSINE", -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_COSINE,  30'd0},
        '{"",       -1, act_pkg::CHAR_NL,   TYPED_NONE,   act_pkg::KIND_INVALID, 30'd0},
        '{"",       -1, act_pkg::CHAR_SEMI, TYPED_NONE,   act_pkg::KIND_INVALID, 30'd0},
        '{"0",      -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_NUMBER,  30'd0},
        '{"12.5",   -1, act_pkg::CHAR_SEMI, TYPED_RESULT, act_pkg::KIND_NUMBER,  30'd12800},
        '{"1048575.9999", -1, act_pkg::CHAR_NL, TYPED_RESULT, act_pkg::KIND_NUMBER,
          30'h3fffffff},
        '{"99999999", -1, act_pkg::CHAR_NL, TYPED_RESULT, act_pkg::KIND_NUMBER,
          30'h3ffffc00},
        '{"  007.06251", -1, act_pkg::CHAR_SEMI, PREDICTED, act_pkg::KIND_NUMBER, 30'd0},
        '{".5",     -1, act_pkg::CHAR_NL,   PREDICTED,    act_pkg::KIND_NUMBER,  30'd0},
        '{"1.2.3",  -1, act_pkg::CHAR_NL,   PREDICTED,    act_pkg::KIND_NUMBER,  30'd0},
        '{"3 4",    -1, act_pkg::CHAR_SEMI, PREDICTED,    act_pkg::KIND_NUMBER,  30'd0},
        '{".",      -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_INVALID, 30'd0},
        '{" ",      -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_INVALID, 30'd0},
        '{"ONE",    -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_INVALID, 30'd0},
        '{"ONxy",    2, act_pkg::CHAR_NL,   PREDICTED,    act_pkg::KIND_ON,      30'd0},
        '{"5",       0, act_pkg::CHAR_SEMI, TYPED_RESULT, act_pkg::KIND_INVALID, 30'd0},
        '{"4\t2",   -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_INVALID, 30'd0},
        '{"a\377",  -1, act_pkg::CHAR_NL,   TYPED_RESULT, act_pkg::KIND_INVALID, 30'd0},
        '{"0000000000000000000000000000007", -1, act_pkg::CHAR_NL, PREDICTED,
          act_pkg::KIND_NUMBER, 30'd0},
        '{"ABCDEFGHIJKLMNOPQRSTUVWXYZ012345", -1, act_pkg::CHAR_SEMI, TYPED_RESULT,
          act_pkg::KIND_OVERFLOW, 30'd0}
    };

    // running token state of the predictor
    int              tok_len;
    logic [6:0]      kw_alive;
    logic            has_digit;
    logic            numeric_only;
    act_pkg::t_phase scan_phase;
    logic [19:0]     int_part;
    int unsigned     frac_acc;
    int              frac_count;
    logic            nul_seen;
    logic            too_long;

    t_token_res expected_tokens [$];
    int         mismatch_count = 0;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_request = 0;
    int         stuck_cycles = 0;

    function automatic void clear_token_state();
        tok_len      = 0;
        kw_alive     = act_pkg::KW_ALL;
        has_digit    = 1'b0;
        numeric_only = 1'b1;
        scan_phase   = act_pkg::PH_SPACES;
        int_part     = '0;
        frac_acc     = 0;
        frac_count   = 0;
        nul_seen     = 1'b0;
        too_long     = 1'b0;
    endfunction

    // advances the token state by one byte, returns 1 when a token result comes out
    function automatic bit predict_token(input logic [7:0] raw, output t_token_res res);
        logic [7:0]  c;
        logic        is_digit;
        logic        found;
        int unsigned pos;
        int unsigned acc;
        int unsigned scale;
        int unsigned frac;
        c   = raw;
        res = t_token_res'{act_pkg::KIND_INVALID, 30'd0};
        if (c != act_pkg::CHAR_NL && c != act_pkg::CHAR_SEMI) begin
            if (c >= act_pkg::CHAR_LOW_A && c <= act_pkg::CHAR_LOW_Z) begin
                c = c - act_pkg::CASE_DIFF;
            end
            if (too_long) begin
                return 1'b0;
            end
            if (tok_len >= BUF_LEN - 1) begin
                too_long = 1'b1;
                return 1'b0;
            end
            if (!nul_seen) begin
                pos = tok_len;
                if (c == act_pkg::CHAR_NUL) begin
                    // only keywords that end exactly here survive
                    for (int k = 0; k < act_pkg::KW_COUNT; k++) begin
                        if (pos != kw_spell[k].len()) kw_alive[k] = 1'b0;
                    end
                    nul_seen = 1'b1;
                end else begin
                    is_digit = (c >= act_pkg::CHAR_ZERO && c <= act_pkg::CHAR_NINE);
                    for (int k = 0; k < act_pkg::KW_COUNT; k++) begin
                        if (!(pos < kw_spell[k].len() && kw_spell[k][pos] == c)) begin
                            kw_alive[k] = 1'b0;
                        end
                    end
                    if (is_digit) begin
                        has_digit = 1'b1;
                    end else if (c != act_pkg::CHAR_SPACE && c != act_pkg::CHAR_POINT) begin
                        numeric_only = 1'b0;
                    end
                    case (scan_phase)
                        act_pkg::PH_SPACES, act_pkg::PH_INT: begin
                            if (is_digit) begin
                                acc        = int_part * 10 + (c - act_pkg::CHAR_ZERO);
                                int_part   = (acc > act_pkg::INT_MAX) ?
                                             act_pkg::INT_MAX : acc[19:0];
                                scan_phase = act_pkg::PH_INT;
                            end else if (c == act_pkg::CHAR_POINT) begin
                                scan_phase = act_pkg::PH_FRAC;
                            end else if (!(c == act_pkg::CHAR_SPACE &&
                                           scan_phase == act_pkg::PH_SPACES)) begin
                                scan_phase = act_pkg::PH_DONE;
                            end
                        end
                        act_pkg::PH_FRAC: begin
                            if (is_digit) begin
                                if (frac_count < FRAC_KEEP) begin
                                    frac_acc = frac_acc * 10 + (c - act_pkg::CHAR_ZERO);
                                    frac_count++;
                                end
                            end else begin
                                scan_phase = act_pkg::PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tok_len++;
            return 1'b0;
        end
        if (tok_len == 0 && !too_long) begin
            return 1'b0;
        end
        if (too_long) begin
            res.kind = act_pkg::KIND_OVERFLOW;
        end else begin
            found = 1'b0;
            for (int k = 0; k < act_pkg::KW_COUNT; k++) begin
                if (!found && kw_alive[k] && (nul_seen || tok_len == kw_spell[k].len())) begin
                    res.kind = act_pkg::t_kind'(k);
                    found    = 1'b1;
                end
            end
            if (!found && has_digit && numeric_only) begin
                scale = 1;
                repeat (frac_count) scale = scale * 10;
                frac = (frac_count > 0) ? (frac_acc * 1024) / scale : 0;
                if (frac > 1023) frac = 1023;
                res.kind  = act_pkg::KIND_NUMBER;
                res.value = {int_part, frac[9:0]};
            end
        end
        clear_token_state();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: token mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // one byte transaction; the predictor sees every accepted byte
    task automatic send_byte(input logic [7:0] b, input bit predicted);
        t_token_res res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid   = 1'b1;
        byte_ch.byte_in = b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        if (predict_token(b, res) && predicted) begin
            expected_tokens.push_back(res);
        end
    endtask

    // mostly well-formed keywords and numbers with random content, some noise
    task automatic send_random_tokens(input int byte_budget);
        logic [7:0] token_bytes [$];
        logic [7:0] c;
        int         pick;
        int         n;
        int         sent;
        sent = 0;
        while (sent < byte_budget) begin
            token_bytes.delete();
            pick = $urandom_range(99);
            if (pick < 30 || (pick >= 80 && pick < 87)) begin
                n = $urandom_range(act_pkg::KW_COUNT - 1);
                for (int i = 0; i < kw_spell[n].len(); i++) begin
                    c = kw_spell[n][i];
                    if ($urandom_range(1)) c = c + act_pkg::CASE_DIFF;
                    token_bytes.push_back(c);
                end
                if (pick >= 80) begin
                    // zero byte ends the text, the rest is junk
                    token_bytes.push_back(act_pkg::CHAR_NUL);
                    repeat ($urandom_range(3)) token_bytes.push_back("A" + 8'($urandom_range(25)));
                end else if ($urandom_range(4) == 0) begin
                    if ($urandom_range(1)) void'(token_bytes.pop_back());
                    else token_bytes.push_back("A" + 8'($urandom_range(25)));
                end
            end else if (pick < 65) begin
                repeat ($urandom_range(2)) token_bytes.push_back(act_pkg::CHAR_SPACE);
                n = ($urandom_range(9) == 0) ? $urandom_range(6, 9) : $urandom_range(4);
                repeat (n) token_bytes.push_back(act_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                if (n == 0 || $urandom_range(3) != 0) begin
                    token_bytes.push_back(act_pkg::CHAR_POINT);
                    repeat ($urandom_range(6)) begin
                        token_bytes.push_back(act_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                    end
                end
                if ($urandom_range(6) == 0) begin
                    case ($urandom_range(2))
                        0: token_bytes.push_back(act_pkg::CHAR_SPACE);
                        1: token_bytes.push_back(act_pkg::CHAR_POINT);
                        default: token_bytes.push_back("A" + 8'($urandom_range(25)));
                    endcase
                    token_bytes.push_back(act_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                end
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 6)) token_bytes.push_back(8'($urandom_range(255)));
            end else if (pick < 92) begin
                // lengths around the buffer limit
                repeat ($urandom_range(29, 36)) token_bytes.push_back("A" + 8'($urandom_range(25)));
            end
            token_bytes.push_back($urandom_range(1) ? act_pkg::CHAR_NL : act_pkg::CHAR_SEMI);
            foreach (token_bytes[i]) send_byte(token_bytes[i], 1'b1);
            sent += token_bytes.size();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver side: random stalls, or a long hold-off when asked
    initial begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen      = 0;
        hold_left      = 0;
        token_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != hold_seen) begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                token_ch.ready = 1'b0;
                hold_left--;
            end else begin
                token_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_token_res want;
        if (token_ch.valid && token_ch.ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("result kind %0d with no token pending",
                                          token_ch.token_kind));
            end else begin
                want = expected_tokens.pop_front();
                if (token_ch.token_kind !== want.kind) begin
                    report_mismatch($sformatf("token_kind %0d, wanted %0d",
                                              token_ch.token_kind, want.kind));
                end
                if (token_ch.number_value !== want.value) begin
                    report_mismatch($sformatf("number_value 0x%08h, wanted 0x%08h",
                                              token_ch.number_value, want.value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_directed_row row;
        byte_ch.valid   = 1'b0;
        byte_ch.byte_in = '0;
        i_rst_n         = 1'b0;
        send_idle_pct   = 11;
        recv_stall_pct  = 73;
        clear_token_state();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            for (int i = 0; i < row.text.len(); i++) begin
                if (i == row.nul_pos) send_byte(act_pkg::CHAR_NUL, 1'b1);
                send_byte(row.text[i], 1'b1);
            end
            send_byte(row.term, row.src == PREDICTED);
            if (row.src == TYPED_RESULT) begin
                expected_tokens.push_back(t_token_res'{row.kind, row.value});
            end
        end

        send_random_tokens(130);

        // sender waits out every result, then the receiver holds off while bytes keep coming
        @(negedge i_clk);
        byte_ch.valid = 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        hold_request++;
        send_random_tokens(60);

        send_idle_pct  = 73;
        recv_stall_pct = 11;
        send_random_tokens(100);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_tokens(100);

        @(negedge i_clk);
        byte_ch.valid = 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
src/act_pkg.sv
src/act_in_if.sv
src/act_out_if.sv
src/act_scan.sv
src/act_classify.sv
src/ascii_command_tokenizer_unit.sv
dv/ascii_command_tokenizer_unit_tb.sv
